### rtl/core/fifo_replacement_kv_cache_macros.svh
// Assertion macros for the FIFO-replacement key/value cache checker
`ifndef FIFO_REPLACEMENT_KV_CACHE_MACROS_SVH
`define FIFO_REPLACEMENT_KV_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define FKV_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fkv assertion failed");

// Next-cycle implication, sampled on clock, off during reset
`define FKV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fkv assertion failed");

`endif

### rtl/core/fkv_pkg.sv
// Package: types, request codes and constants of the FIFO-replacement key/value cache
`timescale 1ns / 1ps

package fkv_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int KEY_WIDTH    = 32;
   localparam int VALUE_WIDTH  = 32;
   localparam int REQ_W        = 3;
   localparam int OCC_W        = 5;
   localparam int LIMIT_W      = 5;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_GET    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ASSIGN = 3'd2;
   localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_TAKE   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

   // Register file
   localparam int               CSR_ADDR_W        = 3;
   localparam int               CSR_DATA_W        = 32;
   localparam logic             REG_MAX_ENTRIES   = 1'b0;
   localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RESET = 5'd16;

   typedef struct packed {
      logic [REQ_W-1:0]       req_type;
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] write_value;
   } fkv_request_type;

   typedef struct packed {
      logic                   hit;
      logic [VALUE_WIDTH-1:0] read_value;
      logic                   inserted;
      logic                   evicted;
      logic [KEY_WIDTH-1:0]   evicted_key;
      logic [OCC_W-1:0]       occupancy;
   } fkv_result_type;

endpackage

### rtl/core/fkv_if.sv
// Valid/ready channel interface carrying one payload per transfer
`timescale 1ns / 1ps

interface fkv_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/fifo_replacement_kv_cache.sv
// Top level of the FIFO-replacement key/value cache
`timescale 1ns / 1ps

// Fully associative key/value cache with FIFO replacement.
// A request enters on req_if (valid/ready) with req_type, key and write_value;
// exactly one result leaves on rsp_if per request, in request order.
// Get, insert, insert_or_assign, erase, take and clear act on CAPACITY slots;
// a new key arriving at the entry limit evicts the oldest entry and reports it.
// The entry limit is register max_entries at byte address 0 of the APB port.
// A request accepted on req_if is held in the input register, then its result
// in the result register, which drives rsp_if until the result is taken.
// Throughput: one request per cycle while results are taken, set by the key
// compare over all slots plus the age-rank update ending in the slot registers.
// A stalled receiver holds the result register; the input register still
// takes one more request, then req_if.ready drops until the result is taken.
// Reset empties the cache (all slots invalid, count zero), sets max_entries
// to 16 and leaves both channels empty; no clearing pass is needed.

module fifo_replacement_kv_cache #(
   parameter int CAPACITY = fkv_pkg::DEF_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   fkv_if.sink                              req_if,
   fkv_if.source                            rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fkv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fkv_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fkv_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import fkv_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   fkv_request_type      s1_req_ff;
   logic                 s2_valid_ff, s2_valid_in;
   fkv_result_type       s2_rsp_ff;
   fkv_result_type       store_result;
   logic [LIMIT_W-1:0]   max_entries_ff;
   logic                 s1_load, s2_load, csr_write;

   assign s2_load      = s1_valid_ff && (!s2_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s2_load;
   assign s1_load      = req_if.valid && req_if.ready;
   assign s1_valid_in  = s1_load || (s1_valid_ff && !s2_load);
   assign s2_valid_in  = s2_load || (s2_valid_ff && !rsp_if.ready);

   assign rsp_if.valid   = s2_valid_ff;
   assign rsp_if.payload = s2_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_req_ff <= req_if.payload;
      end
      if (s2_load) begin
         s2_rsp_ff <= store_result;
      end
   end

   fkv_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .step        (s2_load),
      .request     (s1_req_ff),
      .max_entries (max_entries_ff),
      .result      (store_result)
   );

   // Register port: one register, word index in paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2] == REG_MAX_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else if (csr_write) begin
         max_entries_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_MAX_ENTRIES) begin
         prdata = CSR_DATA_W'(max_entries_ff);
      end
   end

endmodule

### rtl/core/fkv_store.sv
// Slot storage, parallel key match, FIFO age ranks and next-state logic
`timescale 1ns / 1ps

module fkv_store #(
   parameter int CAPACITY = fkv_pkg::DEF_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  fkv_pkg::fkv_request_type      request,
   input  logic [fkv_pkg::LIMIT_W-1:0]   max_entries,
   output fkv_pkg::fkv_result_type       result
);
   import fkv_pkg::*;

   localparam int RW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   logic [CAPACITY-1:0]    slot_valid_ff, slot_valid_in;
   logic [KEY_WIDTH-1:0]   slot_key_ff   [CAPACITY];
   logic [KEY_WIDTH-1:0]   slot_key_in   [CAPACITY];
   logic [VALUE_WIDTH-1:0] slot_value_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] slot_value_in [CAPACITY];
   logic [RW-1:0]          slot_rank_ff  [CAPACITY];
   logic [RW-1:0]          slot_rank_in  [CAPACITY];
   logic [CW-1:0]          entry_count_ff, entry_count_in;

   logic [CAPACITY-1:0]    match, oldest, rm_vec, valid_mid, free_vec, ins_vec;
   logic                   hit_any, is_new, do_evict, do_erase, rm_en, is_clear;
   logic [VALUE_WIDTH-1:0] hit_value;
   logic [KEY_WIDTH-1:0]   oldest_key;
   logic [RW-1:0]          hit_rank, rm_rank;
   logic [CW-1:0]          count_mid;
   logic [LW-1:0]          limit_val, max_ext;

   always_comb begin
      max_ext = LW'(max_entries);
      if (max_ext == '0) begin
         limit_val = LW'(1);
      end else if (max_ext > LW'(CAPACITY)) begin
         limit_val = LW'(CAPACITY);
      end else begin
         limit_val = max_ext;
      end
   end

   // Parallel compare over all slots
   always_comb begin
      hit_value  = '0;
      hit_rank   = '0;
      oldest_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i]  = slot_valid_ff[i] && (slot_key_ff[i] == request.key);
         oldest[i] = slot_valid_ff[i] && (slot_rank_ff[i] == '0);
         if (match[i]) begin
            hit_value = hit_value | slot_value_ff[i];
            hit_rank  = hit_rank | slot_rank_ff[i];
         end
         if (oldest[i]) begin
            oldest_key = oldest_key | slot_key_ff[i];
         end
      end
      hit_any = |match;
   end

   always_comb begin
      is_clear = (request.req_type == REQ_CLEAR);
      is_new   = ((request.req_type == REQ_INSERT) || (request.req_type == REQ_ASSIGN))
                 && !hit_any;
      do_evict = is_new && (entry_count_ff != '0) && (LW'(entry_count_ff) >= limit_val);
      do_erase = ((request.req_type == REQ_ERASE) || (request.req_type == REQ_TAKE))
                 && hit_any;
      rm_en    = do_evict || do_erase;
      rm_vec   = do_evict ? oldest : (do_erase ? match : '0);
      rm_rank  = do_evict ? '0 : hit_rank;

      valid_mid = slot_valid_ff & ~rm_vec;
      count_mid = entry_count_ff - CW'(rm_en);

      // Lowest free slot takes the new key
      free_vec  = ~valid_mid;
      ins_vec   = is_new ? (free_vec & ~(free_vec - CAPACITY'(1))) : '0;

      for (int i = 0; i < CAPACITY; i++) begin
         slot_key_in[i]   = slot_key_ff[i];
         slot_value_in[i] = slot_value_ff[i];
         slot_rank_in[i]  = slot_rank_ff[i];
         if (ins_vec[i]) begin
            slot_key_in[i]   = request.key;
            slot_value_in[i] = request.write_value;
            slot_rank_in[i]  = RW'(count_mid);
         end else begin
            if ((request.req_type == REQ_ASSIGN) && match[i]) begin
               slot_value_in[i] = request.write_value;
            end
            // Close the gap left in the age order
            if (rm_en && valid_mid[i] && (slot_rank_ff[i] > rm_rank)) begin
               slot_rank_in[i] = slot_rank_ff[i] - RW'(1);
            end
         end
      end

      slot_valid_in  = is_clear ? '0 : (valid_mid | ins_vec);
      entry_count_in = is_clear ? '0 : (count_mid + CW'(is_new));
   end

   always_comb begin
      result.hit         = hit_any && (request.req_type <= REQ_TAKE);
      result.read_value  = (((request.req_type == REQ_GET) || (request.req_type == REQ_TAKE))
                            && hit_any) ? hit_value : '0;
      result.inserted    = is_new;
      result.evicted     = do_evict;
      result.evicted_key = do_evict ? oldest_key : '0;
      result.occupancy   = OCC_W'(entry_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff  <= '0;
         entry_count_ff <= '0;
      end else if (step) begin
         slot_valid_ff  <= slot_valid_in;
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         slot_key_ff   <= slot_key_in;
         slot_value_ff <= slot_value_in;
         slot_rank_ff  <= slot_rank_in;
      end
   end

endmodule

### rtl/core/fkv_checker.sv
// Port-level checker for the FIFO-replacement key/value cache, with its bind
`timescale 1ns / 1ps
`include "fifo_replacement_kv_cache_macros.svh"

module fkv_checker (
   input logic   clock,
   input logic   reset,
   fkv_if.source rsp_if
);

   `FKV_ASSERT_NEXT(a_rsp_hold, rsp_if.valid && !rsp_if.ready, rsp_if.valid)

   `FKV_ASSERT_NEXT(a_rsp_stable, rsp_if.valid && !rsp_if.ready, $stable(rsp_if.payload))

   `FKV_ASSERT_NOW(a_evict_is_insert, rsp_if.valid && rsp_if.payload.evicted, rsp_if.payload.inserted && !rsp_if.payload.hit && (rsp_if.payload.occupancy != '0))

   `FKV_ASSERT_NOW(a_read_needs_hit, rsp_if.valid && (rsp_if.payload.read_value != '0), rsp_if.payload.hit && !rsp_if.payload.inserted)

endmodule

bind fifo_replacement_kv_cache fkv_checker u_fkv_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_if (rsp_if)
);
